// File: design/lca_pkg.sv
// ----------------------------------------------------------------------------
// lca_pkg: shared types and constants
// Widths, opcodes and payload structs for the binary-lifting engine.
// ----------------------------------------------------------------------------
package lca_pkg;
  localparam int MaxNodes = 1024;
  localparam int Levels = 10;
  localparam int IdW = 10;
  localparam int LvlW = 4;
  localparam int DepthW = 10;
  localparam int TimeW = 12;
  localparam int AncDepth = MaxNodes * Levels;
  localparam int AncAw = 14;
  localparam int NodeInfoW = DepthW + 2 * TimeW;
  localparam logic [DepthW-1:0] DepthMax = '1;

  typedef enum logic [1:0] {
    OP_ENTER = 2'd0,
    OP_EXIT  = 2'd1,
    OP_LCA   = 2'd2,
    OP_KTH   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]     opcode;
    logic [IdW-1:0] node_id;
    logic           is_root;
    logic [IdW-1:0] parent_id;
    logic [IdW-1:0] second_node;
    logic [IdW-1:0] ancestor_steps;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0] answer_node;
    logic           found;
  } out_item_t;

  function automatic logic [AncAw-1:0] anc_addr(logic [IdW-1:0] v, logic [LvlW-1:0] l);
    logic [AncAw-1:0] a;
    a = AncAw'(v) * AncAw'(Levels) + AncAw'(l);
    return a;
  endfunction
endpackage

// File: design/lca_if.sv
// ----------------------------------------------------------------------------
// lca_in_if / lca_out_if: valid-ready channels
// Carry one input or result transaction per valid and ready edge.
// ----------------------------------------------------------------------------
interface lca_in_if;
  logic valid;
  logic ready;
  lca_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface lca_out_if;
  logic valid;
  logic ready;
  lca_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: design/lca_ram.sv
// ----------------------------------------------------------------------------
// lca_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lca_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/lca_binary_lifting_engine.sv
// ----------------------------------------------------------------------------
// lca_binary_lifting_engine: binary-lifting ancestor table and query engine
// Sequencer around an ancestor RAM and a node-info RAM.
// ----------------------------------------------------------------------------
// One transaction at a time. The ancestor table (1024 x 10 levels) and the
// per-node record (depth, entry time, exit time) live in two RAMs with a
// registered read. Steps from the accepting edge until the next input:
//   enter   parent record, then per level: the 2^i ancestor arrives, is
//           written, and addresses the next read
//   exit    read own record, write exit time
//   common ancestor query: both records; done when one node covers the
//           other, else per level from the top an ancestor read, then its
//           interval record, and a final parent read
//   kth ancestor query: own record read, done when the steps exceed the
//           depth; else a check per level, an ancestor read per set bit
// A query result is held in a result register and moved into the output
// register once that is free; the sequencer holds input off while a result
// waits for the output register, so a stalled receiver adds its stall.
// Enter and exit transactions are taken while an earlier result still sits
// in the output register.
// No clearing pass: entries read before being written give undefined answers.
module lca_binary_lifting_engine (
  input logic clk,
  input logic rst,
  lca_in_if.sink    in_ch,
  lca_out_if.source out_ch
);
  import lca_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_EPAR  = 11'b00000000010,
    S_ELVL  = 11'b00000000100,
    S_QV    = 11'b00000001000,
    S_QB    = 11'b00000010000,
    S_QANC  = 11'b00000100000,
    S_QINFO = 11'b00001000000,
    S_QFIN  = 11'b00010000000,
    S_KTH   = 11'b00100000000,
    S_KTAKE = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state, state_next;

  // item and working registers
  in_item_t        item;
  logic [TimeW-1:0] event_clock;
  logic [IdW-1:0]  cur;       // walking node
  logic [LvlW-1:0] lvl;
  logic [TimeW-1:0] b_in, b_out, v_in, v_out;
  logic [IdW-1:0]  cand;
  logic [DepthW-1:0] enter_depth;
  logic            out_valid;
  out_item_t       out_data;
  out_item_t       res_data, res_next;
  logic            res_load;
  logic            out_free;

  // RAM ports
  logic             anc_we, info_we;
  logic [AncAw-1:0] anc_waddr, anc_raddr;
  logic [IdW-1:0]   anc_wdata, anc_rdata;
  logic [IdW-1:0]   info_waddr, info_raddr;
  logic [NodeInfoW-1:0] info_wdata, info_rdata;

  lca_ram #(.Width(IdW), .Depth(AncDepth)) u_anc (
    .clk(clk), .we(anc_we), .waddr(anc_waddr), .wdata(anc_wdata),
    .raddr(anc_raddr), .rdata(anc_rdata)
  );

  lca_ram #(.Width(NodeInfoW), .Depth(MaxNodes)) u_info (
    .clk(clk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
    .raddr(info_raddr), .rdata(info_rdata)
  );

  // forward an ancestor write that lands on the entry read in the same cycle
  logic           anc_fwd_hit;
  logic [IdW-1:0] anc_fwd_data, anc_q;
  assign anc_q = anc_fwd_hit ? anc_fwd_data : anc_rdata;

  logic [DepthW-1:0] rd_depth;
  logic [TimeW-1:0]  rd_in, rd_out;
  assign rd_depth = info_rdata[NodeInfoW-1 -: DepthW];
  assign rd_in    = info_rdata[2*TimeW-1 -: TimeW];
  assign rd_out   = info_rdata[TimeW-1:0];

  logic [TimeW-1:0] tick;
  assign tick = event_clock + TimeW'(1);

  logic accept;
  assign in_ch.ready = (state == S_IDLE);
  assign accept = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;
  assign out_free = !out_valid || out_ch.ready;

  // parent of an entered node; a root is its own parent
  logic [IdW-1:0] enter_par;
  assign enter_par = item.is_root ? item.node_id : item.parent_id;

  // child depth saturates at the top of its range
  logic [DepthW-1:0] new_depth;
  always_comb begin
    if (rd_depth == DepthMax) new_depth = DepthMax;
    else new_depth = rd_depth + DepthW'(1);
  end

  // interval tests on the record just read
  logic cand_above_b, v_above_b, b_above_v;
  assign cand_above_b = (rd_in <= b_in) && (rd_out >= b_out);
  assign v_above_b    = (v_in <= rd_in) && (v_out >= rd_out);
  assign b_above_v    = (rd_in <= v_in) && (rd_out >= v_out);

  logic [LvlW-1:0] lvl_last;
  assign lvl_last = LvlW'(Levels - 1);

  logic [LvlW-1:0] lvl_p1;
  assign lvl_p1 = lvl + LvlW'(1);

  always_comb begin
    state_next = state;
    anc_we = 1'b0; anc_waddr = '0; anc_wdata = '0;
    anc_raddr = anc_addr(cur, lvl);
    info_we = 1'b0; info_waddr = item.node_id; info_wdata = '0;
    info_raddr = item.node_id;
    res_load = 1'b0; res_next = '0;
    unique case (state)
      S_IDLE: begin
        info_raddr = in_ch.data.node_id;
        if (accept) begin
          unique case (op_t'(in_ch.data.opcode))
            OP_ENTER: begin
              info_raddr = in_ch.data.is_root ? in_ch.data.node_id
                                               : in_ch.data.parent_id;
              state_next = S_EPAR;
            end
            OP_EXIT:  state_next = S_EPAR;
            OP_LCA:   state_next = S_QV;
            OP_KTH:   state_next = S_KTH;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_EPAR: begin
        // info_rdata: parent record (enter) or own record (exit)
        if (op_t'(item.opcode) == OP_EXIT) begin
          info_we = 1'b1;
          info_wdata = {info_rdata[NodeInfoW-1:TimeW], tick};
          state_next = S_IDLE;
        end else begin
          anc_we = 1'b1;
          anc_waddr = anc_addr(item.node_id, '0);
          anc_wdata = enter_par;
          anc_raddr = anc_addr(enter_par, '0);
          state_next = S_ELVL;
        end
      end
      S_ELVL: begin
        // anc_q = 2^lvl ancestor; store it and read its own 2^lvl ancestor
        anc_we = 1'b1;
        anc_waddr = anc_addr(item.node_id, lvl);
        anc_wdata = anc_q;
        anc_raddr = anc_addr(anc_q, lvl);
        if (lvl == LvlW'(1)) begin
          // info_rdata holds own record: keep its exit time
          info_we = 1'b1;
          info_wdata = {enter_depth, tick, rd_out};
        end
        state_next = (lvl == lvl_last) ? S_IDLE : S_ELVL;
      end
      S_QV: begin
        info_raddr = item.second_node;
        state_next = S_QB;
      end
      S_QB: begin
        if (v_above_b) begin
          res_load = 1'b1;
          res_next = '{answer_node: item.node_id, found: 1'b1};
          state_next = S_DONE;
        end else if (b_above_v) begin
          res_load = 1'b1;
          res_next = '{answer_node: item.second_node, found: 1'b1};
          state_next = S_DONE;
        end else begin
          state_next = S_QANC;
        end
      end
      S_QANC: begin
        info_raddr = anc_q;
        state_next = S_QINFO;
      end
      S_QINFO: begin
        if (lvl == '0) begin
          anc_raddr = anc_addr(cand_above_b ? cur : cand, '0);
          state_next = S_QFIN;
        end else begin
          anc_raddr = anc_addr(cand_above_b ? cur : cand, lvl - LvlW'(1));
          state_next = S_QANC;
        end
      end
      S_QFIN: begin
        res_load = 1'b1;
        res_next = '{answer_node: anc_q, found: 1'b1};
        state_next = S_DONE;
      end
      S_KTH: begin
        // info_rdata holds own record throughout the walk
        if (rd_depth < item.ancestor_steps) begin
          res_load = 1'b1;
          res_next = '{answer_node: '0, found: 1'b0};
          state_next = S_DONE;
        end else if (item.ancestor_steps[lvl]) begin
          state_next = S_KTAKE;
        end else if (lvl == lvl_last) begin
          res_load = 1'b1;
          res_next = '{answer_node: cur, found: 1'b1};
          state_next = S_DONE;
        end
      end
      S_KTAKE: begin
        if (lvl == lvl_last) begin
          res_load = 1'b1;
          res_next = '{answer_node: anc_q, found: 1'b1};
          state_next = S_DONE;
        end else begin
          state_next = S_KTH;
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    anc_fwd_hit  <= anc_we && (anc_waddr == anc_raddr);
    anc_fwd_data <= anc_wdata;
    if (rst) begin
      state <= S_IDLE;
      event_clock <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (info_we) event_clock <= tick;
      if (res_load) res_data <= res_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
        out_data <= res_data;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            item <= in_ch.data;
            cur <= in_ch.data.node_id;
            lvl <= (op_t'(in_ch.data.opcode) == OP_LCA) ? lvl_last : '0;
          end
        end
        S_EPAR: begin
          enter_depth <= item.is_root ? '0 : new_depth;
          lvl <= LvlW'(1);
        end
        S_ELVL: lvl <= lvl_p1;
        S_QV: begin
          v_in <= rd_in; v_out <= rd_out;
        end
        S_QB: begin
          b_in <= rd_in; b_out <= rd_out;
        end
        S_QANC: cand <= anc_q;
        S_QINFO: begin
          if (!cand_above_b) cur <= cand;
          lvl <= lvl - LvlW'(1);
        end
        S_KTH: begin
          // advance past a clear step bit
          if (!item.ancestor_steps[lvl]) lvl <= lvl_p1;
        end
        S_KTAKE: begin
          cur <= anc_q;
          lvl <= lvl_p1;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> out_valid) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> $stable(out_data))
    else $error("result changed while waiting");
  a_clock_step: assert property (@(posedge clk) disable iff (rst)
    info_we |=> (event_clock == $past(event_clock) + TimeW'(1)))
    else $error("event clock step");
  a_enter_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_ELVL) |=> !$rose(out_valid)) else $error("enter gave result");
`endif
endmodule
